// ===== hdl/wcie_pkg.sv =====
// ----------------------------------------------------------------------------
// wcie_pkg
// Shared constants, codes and helpers of the word machine instruction executor.
// ----------------------------------------------------------------------------
package wcie_pkg;

   localparam int unsigned WORD_W       = 16;
   localparam int unsigned MEMORY_WORDS = 65536;
   // word index width; the memory depth is taken as a power of two
   localparam int unsigned MEM_AW       = $clog2(MEMORY_WORDS);
   localparam logic [WORD_W-1:0] PC_LOCATION = 16'h0000;

   localparam logic [2:0] OP_REG_ALU = 3'd0;
   localparam logic [2:0] OP_IMM_ALU = 3'd1;
   localparam logic [2:0] OP_LOAD    = 3'd2;
   localparam logic [2:0] OP_STORE   = 3'd3;
   localparam logic [2:0] OP_JZ_LINK = 3'd4;

   localparam logic [3:0] FN_ADD    = 4'd0;
   localparam logic [3:0] FN_SUB    = 4'd1;
   localparam logic [3:0] FN_AND    = 4'd2;
   localparam logic [3:0] FN_OR     = 4'd3;
   localparam logic [3:0] FN_XOR    = 4'd4;
   localparam logic [3:0] FN_NOT    = 4'd5;
   localparam logic [3:0] FN_SRA    = 4'd6;
   localparam logic [3:0] FN_SRL    = 4'd7;
   localparam logic [3:0] FN_SLL    = 4'd8;
   localparam logic [3:0] FN_EQ     = 4'd9;
   localparam logic [3:0] FN_LTS    = 4'd10;
   localparam logic [3:0] FN_LTU    = 4'd11;
   localparam logic [3:0] FN_TOBOOL = 4'd12;

   localparam logic [WORD_W-1:0] WORD_TRUE  = 16'hffff;
   localparam logic [WORD_W-1:0] WORD_FALSE = 16'h0000;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [MEM_AW-1:0] index_type;

   // word address to memory index
   function automatic index_type word_index(input word_type addr);
      return addr[MEM_AW-1:0];
   endfunction

   localparam index_type PC_INDEX  = word_index(PC_LOCATION);
   localparam index_type LAST_WORD = index_type'(MEMORY_WORDS - 1);

endpackage

// ===== hdl/wcie_ram.sv =====
// ----------------------------------------------------------------------------
// wcie_ram
// Single-port synchronous word memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module wcie_ram #(
   parameter int unsigned ADDR_W = 16,
   parameter int unsigned DATA_W = 16
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] address,
   input  logic [DATA_W-1:0] write_data,
   output logic [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0] mem_array [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_array[address] <= write_data;
      end else begin
         rdata_ff <= mem_array[address];
      end
   end

   assign read_data = rdata_ff;

endmodule

// ===== hdl/wcie_alu.sv =====
// ----------------------------------------------------------------------------
// wcie_alu
// Word ALU for register and immediate forms, flags undefined functions.
// ----------------------------------------------------------------------------
module wcie_alu (
   input  logic [3:0]             alu_function,
   input  logic                   imm_form,
   input  wcie_pkg::word_type     operand_a,
   input  wcie_pkg::word_type     operand_b,
   output wcie_pkg::word_type     result,
   output logic                   defined
);
   import wcie_pkg::*;

   always_comb begin
      result  = WORD_FALSE;
      defined = 1'b1;
      unique case (alu_function)
         FN_ADD:    result = operand_a + operand_b;
         FN_SUB:    result = operand_a - operand_b;
         FN_AND:    result = operand_a & operand_b;
         FN_OR:     result = operand_a | operand_b;
         FN_XOR:    result = operand_a ^ operand_b;
         FN_EQ:     result = (operand_a == operand_b) ? WORD_TRUE : WORD_FALSE;
         FN_LTS:    result = ($signed(operand_a) < $signed(operand_b)) ? WORD_TRUE : WORD_FALSE;
         FN_LTU:    result = (operand_a < operand_b) ? WORD_TRUE : WORD_FALSE;
         FN_NOT: begin
            result  = ~operand_a;
            defined = !imm_form;
         end
         FN_SRA: begin
            result  = {operand_a[WORD_W-1], operand_a[WORD_W-1:1]};
            defined = !imm_form;
         end
         FN_SRL: begin
            result  = {1'b0, operand_a[WORD_W-1:1]};
            defined = !imm_form;
         end
         FN_SLL: begin
            result  = {operand_a[WORD_W-2:0], 1'b0};
            defined = !imm_form;
         end
         FN_TOBOOL: begin
            result  = (operand_a != WORD_FALSE) ? WORD_TRUE : WORD_FALSE;
            defined = !imm_form;
         end
         default: defined = 1'b0;
      endcase
   end

endmodule

// ===== hdl/word_cpu_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// word_cpu_instruction_execute
// Executes one decoded instruction against a word memory holding all registers.
// ----------------------------------------------------------------------------
// sequence: after a request is taken, the single memory port reads pc, rs1, rs2
//   and the load word, then writes the data word and the pc; a new request is
//   taken only after the response has been taken
// reset: synchronous; a clearing pass writes zero to all 65536 words, one per
//   cycle, and no request is taken until it finishes
module word_cpu_instruction_execute (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_alu_function,
   input  logic [15:0] req_dest_address,
   input  logic [15:0] req_source_one_address,
   input  logic [15:0] req_source_two_address,
   input  logic [15:0] req_immediate,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_executed,
   output logic        rsp_wrote_memory,
   output logic [15:0] rsp_write_address,
   output logic [15:0] rsp_write_value,
   output logic        rsp_branch_taken,
   output logic [15:0] rsp_next_pc
);
   import wcie_pkg::*;

   // one-hot sequencer states
   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_RD_PC    = 9'b000000100,
      S_RD_A     = 9'b000001000,
      S_RD_B     = 9'b000010000,
      S_RD_LD    = 9'b000100000,
      S_WR_DATA  = 9'b001000000,
      S_WR_PC    = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   index_type  clr_ff, clr_in;

   // captured request
   logic [2:0] op_ff, op_in;
   logic [3:0] func_ff, func_in;
   word_type   rd_ff, rd_in;
   word_type   rs1_ff, rs1_in;
   word_type   rs2_ff, rs2_in;
   word_type   imm_ff, imm_in;

   // operands read from memory
   word_type   pc_ff, pc_in;
   word_type   a_ff, a_in;
   word_type   b_ff, b_in;

   // data write and result
   logic       exec_ff, exec_in;
   word_type   waddr_ff, waddr_in;
   word_type   wval_ff, wval_in;
   logic       taken_ff, taken_in;
   word_type   npc_ff, npc_in;

   // memory port
   logic       mem_we;
   index_type  mem_addr;
   word_type   mem_wdata;
   word_type   mem_rdata;

   // alu
   word_type   alu_result;
   logic       alu_defined;
   logic       imm_form;
   word_type   alu_b;

   // pc update helpers
   word_type   a_fwd;
   word_type   b_fwd;
   word_type   pc_base;
   word_type   eff_addr;

   wcie_ram #(
      .ADDR_W (MEM_AW),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock        (clock),
      .write_enable (mem_we),
      .address      (mem_addr),
      .write_data   (mem_wdata),
      .read_data    (mem_rdata)
   );

   assign imm_form = (op_ff == OP_IMM_ALU);
   assign alu_b    = imm_form ? imm_ff : b_ff;

   wcie_alu u_alu (
      .alu_function (func_ff),
      .imm_form     (imm_form),
      .operand_a    (a_ff),
      .operand_b    (alu_b),
      .result       (alu_result),
      .defined      (alu_defined)
   );

   // base plus offset for load and store
   assign eff_addr = a_ff + imm_ff;

   // jump-and-link reads see its own link write
   assign a_fwd = (op_ff == OP_JZ_LINK && word_index(rs1_ff) == word_index(waddr_ff))
                  ? wval_ff : a_ff;
   assign b_fwd = (op_ff == OP_JZ_LINK && word_index(rs2_ff) == word_index(waddr_ff))
                  ? wval_ff : b_ff;
   // a data write onto the pc word lands before the increment
   assign pc_base = (word_index(waddr_ff) == PC_INDEX) ? wval_ff : pc_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      func_in   = func_ff;
      rd_in     = rd_ff;
      rs1_in    = rs1_ff;
      rs2_in    = rs2_ff;
      imm_in    = imm_ff;
      pc_in     = pc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      exec_in   = exec_ff;
      waddr_in  = waddr_ff;
      wval_in   = wval_ff;
      taken_in  = taken_ff;
      npc_in    = npc_ff;
      mem_we    = 1'b0;
      mem_addr  = PC_INDEX;
      mem_wdata = WORD_FALSE;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one word per cycle
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = WORD_FALSE;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               func_in  = req_alu_function;
               rd_in    = req_dest_address;
               rs1_in   = req_source_one_address;
               rs2_in   = req_source_two_address;
               imm_in   = req_immediate;
               state_in = S_RD_PC;
            end
         end
         S_RD_PC: begin
            mem_addr = PC_INDEX;
            state_in = S_RD_A;
         end
         S_RD_A: begin
            mem_addr = word_index(rs1_ff);
            pc_in    = mem_rdata;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            mem_addr = word_index(rs2_ff);
            a_in     = mem_rdata;
            state_in = S_RD_LD;
         end
         S_RD_LD: begin
            // load word read; harmless for other operations
            mem_addr = word_index(eff_addr);
            b_in     = mem_rdata;
            state_in = S_WR_DATA;
         end
         S_WR_DATA: begin
            exec_in  = 1'b1;
            waddr_in = rd_ff;
            wval_in  = WORD_FALSE;
            unique case (op_ff)
               OP_REG_ALU,
               OP_IMM_ALU: begin
                  exec_in = alu_defined;
                  wval_in = alu_result;
               end
               OP_LOAD:    wval_in = mem_rdata;
               OP_STORE: begin
                  waddr_in = eff_addr;
                  wval_in  = b_ff;
               end
               OP_JZ_LINK: wval_in = pc_ff + 1'b1;
               default:    exec_in = 1'b0;
            endcase
            if (!exec_in) begin
               waddr_in = WORD_FALSE;
               wval_in  = WORD_FALSE;
            end
            mem_we    = exec_in;
            mem_addr  = word_index(waddr_in);
            mem_wdata = wval_in;
            state_in  = S_WR_PC;
         end
         S_WR_PC: begin
            taken_in = exec_ff && op_ff == OP_JZ_LINK && b_fwd == WORD_FALSE;
            if (!exec_ff) begin
               npc_in = pc_ff;
            end else if (taken_in) begin
               npc_in = a_fwd + imm_ff;
            end else begin
               npc_in = pc_base + 1'b1;
            end
            mem_we    = exec_ff;
            mem_addr  = PC_INDEX;
            mem_wdata = npc_in;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      func_ff  <= func_in;
      rd_ff    <= rd_in;
      rs1_ff   <= rs1_in;
      rs2_ff   <= rs2_in;
      imm_ff   <= imm_in;
      pc_ff    <= pc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      exec_ff  <= exec_in;
      waddr_ff <= waddr_in;
      wval_ff  <= wval_in;
      taken_ff <= taken_in;
      npc_ff   <= npc_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_executed      = exec_ff;
   // every defined request writes one data word
   assign rsp_wrote_memory  = exec_ff;
   assign rsp_write_address = waddr_ff;
   assign rsp_write_value   = wval_ff;
   assign rsp_branch_taken  = taken_ff;
   assign rsp_next_pc       = npc_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks word_cpu_instruction_execute against its own model of the machine
// words. Directed instructions cover operand extremes, every ALU function,
// loads, stores, jump-and-link and undefined pairs. Random instructions then
// run under three idling patterns. Each result is compared in order with
// the model's prediction.
// ----------------------------------------------------------------------------
module testbench;
   import wcie_pkg::*;

   // operation and function codes past the last defined one
   localparam logic [2:0] OP_UNDEF_LO = OP_JZ_LINK + 3'd1;
   localparam logic [3:0] FN_UNDEF_LO = FN_TOBOOL + 4'd1;
   localparam int unsigned OP_CODES = 8;
   localparam int unsigned FN_CODES = 16;
   // cycles to wait after the last result
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned MAX_GAP = 12;
   localparam int unsigned RANDOM_PER_PHASE = 375;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] alu_function;
      word_type   dest;
      word_type   src1;
      word_type   src2;
      word_type   imm;
   } instr_type;

   typedef struct packed {
      logic     executed;
      logic     wrote_memory;
      word_type write_address;
      word_type write_value;
      logic     branch_taken;
      word_type next_pc;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [3:0]  req_alu_function = '0;
   logic [15:0] req_dest_address = '0;
   logic [15:0] req_source_one_address = '0;
   logic [15:0] req_source_two_address = '0;
   logic [15:0] req_immediate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_executed;
   logic        rsp_wrote_memory;
   logic [15:0] rsp_write_address;
   logic [15:0] rsp_write_value;
   logic        rsp_branch_taken;
   logic [15:0] rsp_next_pc;

   // model of the word memory, predicted results and run statistics
   word_type    machine_words [MEMORY_WORDS];
   outcome_type pending_outcomes [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned results_checked = 0;
   int unsigned executed_count = 0;
   int unsigned branch_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned orphan_count = 0;

   word_cpu_instruction_execute dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_alu_function       (req_alu_function),
      .req_dest_address       (req_dest_address),
      .req_source_one_address (req_source_one_address),
      .req_source_two_address (req_source_two_address),
      .req_immediate          (req_immediate),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_executed           (rsp_executed),
      .rsp_wrote_memory       (rsp_wrote_memory),
      .rsp_write_address      (rsp_write_address),
      .rsp_write_value        (rsp_write_value),
      .rsp_branch_taken       (rsp_branch_taken),
      .rsp_next_pc            (rsp_next_pc)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // machine model
   // ---------------------------------------------------------------------

   // addresses wrap onto the memory depth
   function automatic word_type read_word(input word_type addr);
      return machine_words[int'(addr) % MEMORY_WORDS];
   endfunction

   function automatic void write_word(input word_type addr, input word_type value);
      machine_words[int'(addr) % MEMORY_WORDS] = value;
   endfunction

   // executes one instruction on the model and returns what the block reports
   function automatic outcome_type execute_instruction(input instr_type ins);
      outcome_type res;
      word_type a;
      word_type b;
      word_type value;
      word_type addr;
      logic     defined;
      res = '0;
      value = '0;
      addr = '0;
      defined = 1'b1;
      case (ins.operation)
         OP_REG_ALU, OP_IMM_ALU: begin
            a = read_word(ins.src1);
            b = (ins.operation == OP_REG_ALU) ? read_word(ins.src2) : ins.imm;
            addr = ins.dest;
            case (ins.alu_function)
               FN_ADD: value = a + b;
               FN_SUB: value = a - b;
               FN_AND: value = a & b;
               FN_OR:  value = a | b;
               FN_XOR: value = a ^ b;
               FN_EQ:  value = (a == b) ? WORD_TRUE : WORD_FALSE;
               FN_LTS: value = ($signed(a) < $signed(b)) ? WORD_TRUE : WORD_FALSE;
               FN_LTU: value = (a < b) ? WORD_TRUE : WORD_FALSE;
               // single-operand functions only exist in register form
               FN_NOT:    value = ~a;
               FN_SRA:    value = {a[WORD_W-1], a[WORD_W-1:1]};
               FN_SRL:    value = {1'b0, a[WORD_W-1:1]};
               FN_SLL:    value = {a[WORD_W-2:0], 1'b0};
               FN_TOBOOL: value = (a != '0) ? WORD_TRUE : WORD_FALSE;
               default:   defined = 1'b0;
            endcase
            if (ins.operation == OP_IMM_ALU &&
                (ins.alu_function == FN_NOT || ins.alu_function == FN_SRA ||
                 ins.alu_function == FN_SRL || ins.alu_function == FN_SLL ||
                 ins.alu_function == FN_TOBOOL))
               defined = 1'b0;
         end
         OP_LOAD: begin
            addr = ins.dest;
            value = read_word(read_word(ins.src1) + ins.imm);
         end
         OP_STORE: begin
            addr = read_word(ins.src1) + ins.imm;
            value = read_word(ins.src2);
         end
         OP_JZ_LINK: begin
            addr = ins.dest;
            value = read_word(PC_LOCATION) + 16'd1;
         end
         default: defined = 1'b0;
      endcase
      if (defined) begin
         res.executed = 1'b1;
         res.wrote_memory = 1'b1;
         res.write_address = addr;
         res.write_value = value;
         // data write first, then the pc; the jump test sees the link word
         write_word(addr, value);
         if (ins.operation == OP_JZ_LINK && read_word(ins.src2) == '0) begin
            res.branch_taken = 1'b1;
            write_word(PC_LOCATION, read_word(ins.src1) + ins.imm);
         end else begin
            write_word(PC_LOCATION, read_word(PC_LOCATION) + 16'd1);
         end
      end
      res.next_pc = read_word(PC_LOCATION);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // presents one request, waits for it to be taken, then predicts its result
   task automatic send_request(input instr_type ins);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= ins.operation;
      req_alu_function <= ins.alu_function;
      req_dest_address <= ins.dest;
      req_source_one_address <= ins.src1;
      req_source_two_address <= ins.src2;
      req_immediate <= ins.imm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      pending_outcomes.push_back(execute_instruction(ins));
   endtask

   task automatic issue(input logic [2:0] op, input logic [3:0] fn, input word_type rd,
                        input word_type rs1, input word_type rs2, input word_type imm);
      instr_type ins;
      ins = '{operation: op, alu_function: fn, dest: rd, src1: rs1, src2: rs2, imm: imm};
      send_request(ins);
   endtask

   // mostly a few hot registers so results feed later instructions
   function automatic word_type pick_address();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return word_type'($urandom_range(0, 15));
      if (r < 90) return word_type'($urandom_range(0, 255));
      return word_type'($urandom_range(0, 65535));
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic instr_type random_instruction();
      instr_type ins;
      int unsigned tries;
      ins.dest = pick_address();
      ins.src1 = pick_address();
      ins.src2 = pick_address();
      ins.imm = pick_operand();
      if ($urandom_range(99) < 6)
         ins.operation = 3'($urandom_range(OP_UNDEF_LO, OP_CODES - 1));
      else
         ins.operation = 3'($urandom_range(OP_REG_ALU, OP_JZ_LINK));
      if ($urandom_range(99) < 8)
         ins.alu_function = 4'($urandom_range(FN_UNDEF_LO, FN_CODES - 1));
      else
         ins.alu_function = 4'($urandom_range(FN_ADD, FN_TOBOOL));
      // aim most effective addresses back into the hot registers
      if ((ins.operation == OP_LOAD || ins.operation == OP_STORE) &&
          $urandom_range(99) < 60)
         ins.imm = word_type'($urandom_range(0, 15)) - read_word(ins.src1);
      // find a zero word half the time so the jump gets taken
      if (ins.operation == OP_JZ_LINK && $urandom_range(1) == 1) begin
         tries = 0;
         while (read_word(ins.src2) != '0 && tries < 8) begin
            ins.src2 = word_type'($urandom_range(0, 65535));
            tries++;
         end
      end
      return ins;
   endfunction

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{executed: rsp_executed, wrote_memory: rsp_wrote_memory,
                  write_address: rsp_write_address, write_value: rsp_write_value,
                  branch_taken: rsp_branch_taken, next_pc: rsp_next_pc};
         if (pending_outcomes.size() == 0) begin
            orphan_count++;
            $display("unexpected result at %0t: exec=%0b pc=%h", $realtime,
                     seen.executed, seen.next_pc);
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (seen.executed) executed_count++;
            if (seen.branch_taken) branch_count++;
            if (seen.executed !== want.executed ||
                seen.wrote_memory !== want.wrote_memory ||
                seen.write_address !== want.write_address ||
                seen.write_value !== want.write_value ||
                seen.branch_taken !== want.branch_taken ||
                seen.next_pc !== want.next_pc) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at %0t result %0d", $realtime, results_checked);
                  $display("  expected exec=%0b wr=%0b addr=%h val=%h br=%0b pc=%h",
                           want.executed, want.wrote_memory, want.write_address,
                           want.write_value, want.branch_taken, want.next_pc);
                  $display("  got      exec=%0b wr=%0b addr=%h val=%h br=%0b pc=%h",
                           seen.executed, seen.wrote_memory, seen.write_address,
                           seen.write_value, seen.branch_taken, seen.next_pc);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // loads the extremes into r1..r3, then every register form function
   task automatic test_alu_extremes();
      issue(OP_IMM_ALU, FN_ADD, 16'd1, 16'h0100, 16'd0, 16'h7fff);
      issue(OP_IMM_ALU, FN_ADD, 16'd2, 16'h0100, 16'd0, 16'h8000);
      issue(OP_IMM_ALU, FN_ADD, 16'd3, 16'h0100, 16'd0, 16'hffff);
      issue(OP_REG_ALU, FN_ADD, 16'd4, 16'd3, 16'd3, 16'h0000);   // wraps
      issue(OP_REG_ALU, FN_SUB, 16'd5, 16'd1, 16'd2, 16'h0000);   // borrows
      issue(OP_REG_ALU, FN_AND, 16'd6, 16'd3, 16'd1, 16'h0000);
      issue(OP_REG_ALU, FN_OR,  16'd7, 16'd1, 16'd2, 16'h0000);
      issue(OP_REG_ALU, FN_XOR, 16'd8, 16'd3, 16'd1, 16'h0000);
      issue(OP_REG_ALU, FN_NOT, 16'd9, 16'd1, 16'd0, 16'h0000);
      issue(OP_REG_ALU, FN_SRA, 16'd10, 16'd2, 16'd0, 16'h0000);  // keeps sign
      issue(OP_REG_ALU, FN_SRL, 16'd11, 16'd2, 16'd0, 16'h0000);
      issue(OP_REG_ALU, FN_SLL, 16'hffff, 16'd3, 16'd0, 16'h0000); // top word
      issue(OP_REG_ALU, FN_EQ,  16'd12, 16'd1, 16'd1, 16'h0000);
      issue(OP_REG_ALU, FN_LTS, 16'd13, 16'd2, 16'd1, 16'h0000);  // signed true
      issue(OP_REG_ALU, FN_LTU, 16'd14, 16'd2, 16'd1, 16'h0000);  // unsigned false
      issue(OP_REG_ALU, FN_TOBOOL, 16'd15, 16'd3, 16'd0, 16'h0000);
   endtask

   // immediate equality compares rs1 with the immediate
   task automatic test_immediate_compare();
      issue(OP_IMM_ALU, FN_EQ, 16'd16, 16'd1, 16'd2, 16'h7fff);
   endtask

   // effective addresses that wrap past the top of the memory
   task automatic test_load_store();
      issue(OP_LOAD,  FN_ADD, 16'd17, 16'd1, 16'd0, 16'h8003);
      issue(OP_STORE, FN_ADD, 16'd0,  16'd3, 16'd2, 16'h0013);
   endtask

   // taken, not taken, and link written onto the pc then tested
   task automatic test_jump_and_link();
      issue(OP_JZ_LINK, FN_ADD, 16'd20, 16'd1, 16'h0100, 16'h0005);
      issue(OP_JZ_LINK, FN_ADD, 16'd21, 16'd1, 16'd3, 16'h0005);
      issue(OP_JZ_LINK, FN_ADD, PC_LOCATION, 16'd2, PC_LOCATION, 16'h0001);
   endtask

   // data write onto the pc word, then the increment on top of it
   task automatic test_pc_destination();
      issue(OP_IMM_ALU, FN_ADD, PC_LOCATION, 16'h0100, 16'd0, 16'hffff);
   endtask

   // nothing may change, pc included
   task automatic test_undefined_pairs();
      issue(OP_IMM_ALU, FN_NOT, 16'd1, 16'd1, 16'd0, 16'h1234);
      issue(3'(OP_CODES - 1), FN_ADD, 16'd1, 16'd2, 16'd3, 16'hffff);
      issue(OP_REG_ALU, 4'(FN_CODES - 1), 16'd1, 16'd2, 16'd3, 16'h0000);
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RANDOM_PER_PHASE) send_request(random_instruction());
   endtask

   initial begin
      foreach (machine_words[i]) machine_words[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the block clears its memory after reset; the first request waits on ready
      test_alu_extremes();
      test_immediate_compare();
      test_load_store();
      test_jump_and_link();
      test_pc_destination();
      test_undefined_pairs();
      test_random_traffic(34, 50);
      test_random_traffic(50, 34);
      test_random_traffic(0, 0);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("issued %0d instructions, checked %0d results: %0d executed, %0d jumps taken",
               requests_sent, results_checked, executed_count, branch_count);
      $display("mismatching results %0d, results without a request %0d",
               mismatch_count, orphan_count);
      if (mismatch_count == 0 && orphan_count == 0 && pending_outcomes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog; a correct run needs well under a quarter of this
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
